>>> hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared command codes, queue entry type and phase helpers.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int WAIT_BITS   = 16;
    localparam int PHASE_BITS  = 6;
    localparam int XFER_PHASES = 27;
    localparam int BIT_PHASES  = 4;
    localparam int DATA_SLOTS  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] WAIT_MAX   = 32'((64'd1 << WAIT_BITS) - 64'd1);
    localparam logic [15:0] WAIT_RESET = 16'd400;
    localparam logic [7:0]  RESET_BYTE = 8'hFF;

    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_XFER  = 3'd3;
    localparam logic [2:0] OP_RESET = 3'd4;

    typedef enum logic [4:0] {
        CMD_IDLE  = 5'b00001,
        CMD_START = 5'b00010,
        CMD_STOP  = 5'b00100,
        CMD_XFER  = 5'b01000,
        CMD_RESET = 5'b10000
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       ack_drive;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [3:0] slot;
        logic [1:0] sub;
    } slot_t;

    // Splits a transfer phase number below 27 into its bit slot and sub-phase.
    function automatic slot_t split_phase(input logic [4:0] x);
        logic [8:0] prod;
        slot_t      r;
        prod   = {4'd0, x} * 9'd11;
        r.slot = prod[8:5];
        r.sub  = 2'(x - 5'(r.slot) * 5'd3);
        return r;
    endfunction

    function automatic logic [PHASE_BITS-1:0] total_phases(input cmd_t c);
        logic [PHASE_BITS-1:0] n;
        case (c)
            CMD_START, CMD_STOP: n = PHASE_BITS'(BIT_PHASES);
            CMD_XFER:            n = PHASE_BITS'(XFER_PHASES);
            default:             n = PHASE_BITS'(BIT_PHASES + XFER_PHASES);
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/i2cms_front.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer front end
// Decodes the operation field of each item into a one-hot command.
// ----------------------------------------------------------------------------
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic [2:0] operation,
    input  logic [7:0] tx_byte,
    input  logic       ack_drive,
    input  logic       sda_in,
    output item_t      item
);

    always_comb begin
        item.tx_byte   = tx_byte;
        item.ack_drive = ack_drive;
        item.sda_in    = sda_in;
        case (operation)
            OP_START: item.cmd = CMD_START;
            OP_STOP:  item.cmd = CMD_STOP;
            OP_XFER:  item.cmd = CMD_XFER;
            OP_RESET: item.cmd = CMD_RESET;
            default:  item.cmd = CMD_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/i2cms_queue.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer item queue
// Two-entry queue that decouples the front end from the sequencer.
// ----------------------------------------------------------------------------
module i2cms_queue
    import i2cms_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  not_full,
    input  logic  pop,
    output logic  not_empty,
    output item_t head
);

    item_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign not_full  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + QPTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_BITS'(1);
                2'b01:   count_reg <= count_reg - QCNT_BITS'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> hw/rtl/i2cms_back.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer back end
// Runs the phase sequencer one item per tick and holds the result register.
// ----------------------------------------------------------------------------
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] wait_ticks,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_release,
    output logic        m_sda_release,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_rx_byte,
    output logic        m_ack_sampled
);

    cmd_t                  cmd_reg, cmd_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [WAIT_BITS-1:0]  wait_reg, wait_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  ack_level_reg, ack_level_next;
    logic                  scl_reg, scl_next;
    logic                  sda_reg, sda_next;
    logic                  rx_ack_reg, rx_ack_next;
    logic                  done_next;
    logic                  out_valid_reg;
    logic                  out_done_reg;

    logic [31:0]           wait_wide;
    logic [WAIT_BITS-1:0]  limit;
    logic                  in_xfer;
    logic [4:0]            xidx;
    slot_t                 sp;
    logic [PHASE_BITS-1:0] phase_inc;

    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    assign wait_wide = 32'(wait_ticks);
    assign limit     = (wait_ticks == 16'd0) ? WAIT_BITS'(1)
                     : (wait_wide > WAIT_MAX) ? WAIT_BITS'(WAIT_MAX) : WAIT_BITS'(wait_wide);
    assign in_xfer = (cmd_reg == CMD_XFER) ||
                     ((cmd_reg == CMD_RESET) && (phase_reg >= PHASE_BITS'(BIT_PHASES)));
    assign xidx    = (cmd_reg == CMD_XFER) ? phase_reg[4:0]
                                           : phase_reg[4:0] - 5'(BIT_PHASES);
    assign sp        = split_phase(xidx);
    assign phase_inc = phase_reg + PHASE_BITS'(1);

    always_comb begin
        cmd_next       = cmd_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        shift_next     = shift_reg;
        ack_level_next = ack_level_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        rx_ack_next    = rx_ack_reg;
        done_next      = 1'b0;
        if (cmd_reg == CMD_IDLE) begin
            if (q_item.cmd != CMD_IDLE) begin
                cmd_next   = q_item.cmd;
                phase_next = '0;
                wait_next  = '0;
                if (q_item.cmd == CMD_XFER) begin
                    shift_next     = q_item.tx_byte;
                    ack_level_next = q_item.ack_drive;
                end else if (q_item.cmd == CMD_RESET) begin
                    shift_next     = RESET_BYTE;
                    ack_level_next = 1'b1;
                end
            end
        end else begin
            if (in_xfer && (sp.sub == 2'd2) && (wait_reg == '0)) begin
                if (sp.slot < 4'(DATA_SLOTS)) begin
                    shift_next = {shift_reg[6:0], q_item.sda_in};
                end else begin
                    rx_ack_next = q_item.sda_in;
                end
            end
            if ({1'b0, wait_reg} + (WAIT_BITS + 1)'(1) >= {1'b0, limit}) begin
                if (in_xfer) begin
                    case (sp.sub)
                        2'd0:    sda_next = (sp.slot < 4'(DATA_SLOTS)) ? shift_reg[7]
                                                                        : ack_level_reg;
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end else if (cmd_reg == CMD_START) begin
                    case (phase_reg[1:0])
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end else begin
                    case (phase_reg[1:0])
                        2'd0:    scl_next = 1'b0;
                        2'd1:    sda_next = 1'b0;
                        2'd2:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                wait_next  = '0;
                phase_next = phase_inc;
                if (phase_inc >= total_phases(cmd_reg)) begin
                    cmd_next   = CMD_IDLE;
                    phase_next = '0;
                    done_next  = 1'b1;
                end
            end else begin
                wait_next = wait_reg + WAIT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_IDLE;
            phase_reg     <= '0;
            wait_reg      <= '0;
            shift_reg     <= '0;
            ack_level_reg <= 1'b1;
            scl_reg       <= 1'b0;
            sda_reg       <= 1'b0;
            rx_ack_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_done_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                cmd_reg       <= cmd_next;
                phase_reg     <= phase_next;
                wait_reg      <= wait_next;
                shift_reg     <= shift_next;
                ack_level_reg <= ack_level_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                rx_ack_reg    <= rx_ack_next;
                out_done_reg  <= done_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_scl_release = scl_reg;
    assign m_sda_release = sda_reg;
    assign m_busy_res    = (cmd_reg != CMD_IDLE);
    assign m_done_res    = out_done_reg;
    assign m_rx_byte     = shift_reg;
    assign m_ack_sampled = rx_ack_reg;

endmodule

>>> hw/rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Bit-level I2C master on open-drain lines, one input item per bus tick.
//
// Each input item on the s_ channel is one tick: it carries the sampled SDA
// level and, while the sequencer is idle, may start a start, stop, byte
// transfer or bus reset command. Every accepted item yields exactly one
// result item on the m_ channel with the line levels, busy and done flags,
// the shift register contents and the last sampled ACK level.
// The wait_ticks register sets the ticks before each line change. The block
// does not check it: write it via cfg_wr_en and cfg_wr_data only while idle.
// An item passes the decoder, a two-entry queue and the sequencer, whose
// result register drives the m_ ports: the item is registered in the queue,
// then in the result register; while the receiver does not stall, one item
// is taken every cycle, set by the sequencer step and its result register.
// When the receiver stalls, the result register holds, the queue fills and
// s_ready falls once two items wait. Reset clears the queue, the sequencer
// state and the result register, and sets wait_ticks to 400.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_tx_byte,
    input  logic        s_ack_drive,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_release,
    output logic        m_sda_release,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_rx_byte,
    output logic        m_ack_sampled
);

    logic [15:0] wait_ticks_reg;
    item_t       dec_item;
    item_t       head_item;
    logic        q_valid;
    logic        q_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_ticks_reg <= WAIT_RESET;
        end else if (cfg_wr_en) begin
            wait_ticks_reg <= cfg_wr_data;
        end
    end

    i2cms_front u_front (
        .operation (s_operation),
        .tx_byte   (s_tx_byte),
        .ack_drive (s_ack_drive),
        .sda_in    (s_sda_in),
        .item      (dec_item)
    );

    i2cms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (dec_item),
        .not_full  (s_ready),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_item)
    );

    i2cms_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .wait_ticks    (wait_ticks_reg),
        .q_valid       (q_valid),
        .q_item        (head_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_release (m_scl_release),
        .m_sda_release (m_sda_release),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_rx_byte     (m_rx_byte),
        .m_ack_sampled (m_ack_sampled)
    );

endmodule
